### src/sacl_pkg.sv
// shared types for the set-associative lru lookup core
// no dependencies
`default_nettype none
package sacl_pkg;
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_SCAN,
        ST_WRITE,
        ST_OUT,
        ST_CLEAR
    } state_t;
    localparam logic [0:0] CFG_SETS = 1'b0;
    localparam logic [0:0] CFG_WAYS = 1'b1;
endpackage
`default_nettype wire

### src/sacl_divider.sv
// restoring serial divider, one quotient bit per cycle
// uses nothing from the package
`default_nettype none
module sacl_divider #(
    parameter int ADDR_BITS = 32,
    parameter int DIV_BITS = 7
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [ADDR_BITS-1:0] dividend,
    input  wire logic [DIV_BITS-1:0]  divisor,
    output logic                      done,
    output logic [ADDR_BITS-1:0]      quotient,
    output logic [DIV_BITS-1:0]       remainder
);
    localparam int CW = $clog2(ADDR_BITS + 1);
    logic [ADDR_BITS-1:0] q_reg;
    logic [DIV_BITS:0]    r_reg;
    logic [DIV_BITS-1:0]  d_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic [DIV_BITS:0]    trial;
    logic [DIV_BITS:0]    diff;

    assign trial = {r_reg[DIV_BITS-1:0], q_reg[ADDR_BITS-1]};
    assign diff = trial - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CW'(ADDR_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DIV_BITS])
            begin
                r_reg <= diff;
                q_reg <= {q_reg[ADDR_BITS-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[ADDR_BITS-2:0], 1'b0};
            end
        end
    end

    assign quotient = q_reg;
    assign remainder = r_reg[DIV_BITS-1:0];
endmodule
`default_nettype wire

### src/set_assoc_cache_lru_lookup_core.sv
// top level: tag store with per-set lru ranks, serial divider for set and tag
// depends on sacl_pkg and sacl_divider
//
// channel   signals                           direction
// in        in_valid in_ready address         into block
// out       out_valid out_ready address_echo hit   out of block
// cfg       cfg_valid cfg_ready cfg_index cfg_data into block
//
// each word goes through the serial divider for set and tag, then one way of
// the set is checked per cycle, up to a hit or the last way.
// reset sets config at once; a clearing pass then zeroes the valid bits and
// ranks of every set, with in_ready low meanwhile.
// a held result blocks the next word; cfg is always ready.
`default_nettype none
module set_assoc_cache_lru_lookup_core import sacl_pkg::*; #(
    parameter int MAX_SETS = 64,
    parameter int MAX_WAYS = 8,
    parameter int ADDR_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] address,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      address_echo,
    output logic             hit,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RW = WW;
    localparam int LINES = MAX_SETS * MAX_WAYS;
    localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int SC = $clog2(MAX_SETS + 1);

    state_t state_reg, state_next;
    logic [6:0] sets_reg;
    logic [3:0] ways_reg;
    logic [31:0] addr_reg;
    logic hit_reg;
    logic [ADDR_BITS-1:0] tag_reg;
    logic [SW-1:0] set_reg;
    logic [WW:0] way_reg;
    logic [WW-1:0] victim_reg;
    logic found_inv_reg;
    logic [SW-1:0] clr_reg;
    logic [MAX_WAYS-1:0] valid_mem [MAX_SETS];
    logic [MAX_WAYS-1:0][RW-1:0] rank_mem [MAX_SETS];
    logic [MAX_WAYS-1:0] rv_reg;
    logic [MAX_WAYS-1:0][RW-1:0] rr_reg;
    logic [MAX_WAYS-1:0] valid_new;
    logic [MAX_WAYS-1:0][RW-1:0] rank_new;
    logic [ADDR_BITS-1:0] tag_mem [LINES];
    logic [ADDR_BITS-1:0] tag_rd_reg;
    logic [ADDR_BITS-1:0] a_ext;
    logic [SC-1:0] sets_eff;
    logic [4:0] ways_eff;
    logic div_start, div_done;
    logic [ADDR_BITS-1:0] quo;
    logic [6:0] rem;
    logic [LW-1:0] line;
    logic [LW-1:0] rd_line;
    logic [WW-1:0] wcur;
    logic line_v;
    logic do_touch;
    logic [WW-1:0] touch_way;

    generate
        if (ADDR_BITS >= 32)
        begin : g_wide
            assign a_ext = ADDR_BITS'(address);
        end
        else
        begin : g_narrow
            assign a_ext = address[ADDR_BITS-1:0];
        end
    endgenerate

    always_comb
    begin
        if (sets_reg == 7'd0)
            sets_eff = SC'(1);
        else if (32'(sets_reg) > 32'(MAX_SETS))
            sets_eff = SC'(MAX_SETS);
        else
            sets_eff = SC'(sets_reg);
        if (ways_reg == 4'd0)
            ways_eff = 5'd1;
        else if (32'(ways_reg) > 32'(MAX_WAYS))
            ways_eff = 5'(MAX_WAYS);
        else
            ways_eff = {1'b0, ways_reg};
    end

    sacl_divider #(.ADDR_BITS(ADDR_BITS), .DIV_BITS(7)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(a_ext),
        .divisor(7'(sets_eff)), .done(div_done), .quotient(quo), .remainder(rem)
    );

    assign wcur = way_reg[WW-1:0];
    assign line = LW'(32'(set_reg) * MAX_WAYS + 32'(wcur));
    assign line_v = rv_reg[wcur];
    assign in_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = (state_reg == ST_OUT);
    assign address_echo = addr_reg;
    assign hit = hit_reg;
    assign div_start = in_valid && in_ready;

    always_comb
    begin
        rd_line = line;
        if (state_reg == ST_READ)
            rd_line = LW'(32'(set_reg) * MAX_WAYS);
        else if (state_reg == ST_SCAN)
            rd_line = line + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        tag_rd_reg <= tag_mem[(32'(rd_line) < LINES) ? rd_line : '0];
        if (state_reg == ST_WRITE && !hit_reg)
            tag_mem[LW'(32'(set_reg) * MAX_WAYS + 32'(victim_reg))] <= tag_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == SW'(MAX_SETS - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (div_start) state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_READ;
            ST_READ:  state_next = ST_SCAN;
            ST_SCAN:
            begin
                if ((line_v && tag_rd_reg == tag_reg) || (way_reg + 1'b1 == ways_eff[WW:0]))
                    state_next = ST_WRITE;
            end
            ST_WRITE: state_next = ST_OUT;
            ST_OUT:   if (out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    assign do_touch = (state_reg == ST_WRITE);
    assign touch_way = hit_reg ? wcur : victim_reg;

    always_comb
    begin
        rank_new = rr_reg;
        valid_new = rv_reg;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (WW'(w) == touch_way)
                rank_new[w] = RW'(MAX_WAYS - 1);
            else if (rr_reg[w] > rr_reg[touch_way])
                rank_new[w] = rr_reg[w] - 1'b1;
        end
        if (!hit_reg)
            valid_new[touch_way] = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            valid_mem[clr_reg] <= '0;
            rank_mem[clr_reg] <= '0;
        end
        else if (do_touch)
        begin
            valid_mem[set_reg] <= valid_new;
            rank_mem[set_reg] <= rank_new;
        end
        if (state_reg == ST_READ)
        begin
            rv_reg <= valid_mem[set_reg];
            rr_reg <= rank_mem[set_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            sets_reg <= 7'd64;
            ways_reg <= 4'd1;
            clr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SETS: sets_reg <= cfg_data[6:0];
                    CFG_WAYS: ways_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
            addr_reg <= address;
        if (state_reg == ST_DIV && div_done)
        begin
            tag_reg <= quo;
            set_reg <= SW'(rem);
            way_reg <= '0;
            hit_reg <= 1'b0;
            victim_reg <= '0;
            found_inv_reg <= 1'b0;
        end
        if (state_reg == ST_SCAN)
        begin
            if (line_v && tag_rd_reg == tag_reg)
                hit_reg <= 1'b1;
            else
            begin
                way_reg <= way_reg + 1'b1;
                if (!found_inv_reg)
                begin
                    if (!line_v)
                    begin
                        victim_reg <= wcur;
                        found_inv_reg <= 1'b1;
                    end
                    else if (wcur != '0 && rr_reg[wcur] < rr_reg[victim_reg])
                        victim_reg <= wcur;
                end
            end
        end
    end
endmodule
`default_nettype wire

### test/tb_set_assoc_cache_lru_lookup_core.sv
// testbench for set_assoc_cache_lru_lookup_core: table, cfg cases, random addresses
// depends on sacl_pkg and the core; predicts hit/miss with its own lru tag store
`default_nettype none
module tb_set_assoc_cache_lru_lookup_core;
    import sacl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSETS = 64;
    localparam int NWAYS = 8;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic [31:0] addr;
        logic        hit;
    } lookup_t;

    typedef struct {
        logic [31:0] addr;
        logic        chk;
        logic        hit;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] address = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] address_echo;
    logic        hit;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = CFG_SETS;
    logic [31:0] cfg_data = '0;

    logic        tv [NSETS*NWAYS];
    logic [31:0] ttag [NSETS*NWAYS];
    logic [2:0]  trank [NSETS*NWAYS];
    logic [6:0]  sets_reg;
    logic [3:0]  ways_reg;

    lookup_t     pending [$];
    logic        pend_chk [$];
    lookup_t     typed [$];
    int          errors = 0;
    int          cycles = 0;
    bit          calm = 1'b0;
    row_t        rows [$];

    always #4 clk = ~clk;

    set_assoc_cache_lru_lookup_core uut (.*);

    function automatic void touch_way(int base, int w);
        logic [2:0] r;
        r = trank[base + w];
        for (int v = 0; v < NWAYS; v++)
            if (v != w && trank[base + v] > r)
                trank[base + v]--;
        trank[base + w] = 3'(NWAYS - 1);
    endfunction

    function automatic logic lookup_and_fill(logic [31:0] a);
        int s, w, base, victim;
        logic [31:0] tg;
        bit found;
        s = sets_reg == 0 ? 1 : (sets_reg > NSETS ? NSETS : sets_reg);
        w = ways_reg == 0 ? 1 : (ways_reg > NWAYS ? NWAYS : ways_reg);
        base = (a % s) * NWAYS;
        tg = a / s;
        found = 1'b0;
        victim = 0;
        for (int i = 0; i < w; i++)
            if (tv[base + i] && ttag[base + i] == tg)
            begin
                touch_way(base, i);
                return 1'b1;
            end
        for (int i = 0; i < w; i++)
            if (!found && !tv[base + i])
            begin
                victim = i;
                found = 1'b1;
            end
        if (!found)
            for (int i = 1; i < w; i++)
                if (trank[base + i] < trank[base + victim])
                    victim = i;
        tv[base + victim] = 1'b1;
        ttag[base + victim] = tg;
        touch_way(base, victim);
        return 1'b0;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("[set_assoc_cache_lru_lookup_core] ERROR");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (pending.size() == 0)
            begin
                $display("%0t unexpected word addr %h hit %b", $time, address_echo, hit);
                errors++;
            end
            else
            begin
                lookup_t e;
                logic c;
                e = pending.pop_front();
                c = pend_chk.pop_front();
                if (e.addr !== address_echo || e.hit !== hit)
                begin
                    $display("%0t mismatch expected %h/%b actual %h/%b",
                             $time, e.addr, e.hit, address_echo, hit);
                    errors++;
                end
                if (c && typed.size() > 0)
                begin
                    lookup_t t;
                    t = typed.pop_front();
                    if (t.hit !== hit)
                    begin
                        $display("%0t table mismatch expected %b actual %b",
                                 $time, t.hit, hit);
                        errors++;
                    end
                end
            end
        end
    end

    always @(negedge clk)
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 28);

    task automatic write_reg(logic [0:0] idx, logic [31:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_SETS) sets_reg = d[6:0];
        else ways_reg = d[3:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_addr(logic [31:0] a, logic c, logic h);
        lookup_t e;
        @(negedge clk);
        while (!calm && $urandom_range(99) < 28) @(negedge clk);
        in_valid <= 1'b1;
        address <= a;
        do @(posedge clk); while (!in_ready);
        e.addr = a;
        e.hit = lookup_and_fill(a);
        pending.push_back(e);
        pend_chk.push_back(c);
        if (c)
        begin
            e.hit = h;
            typed.push_back(e);
        end
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending.size() > 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_addr(int pool);
        int s;
        s = sets_reg == 0 ? 1 : (sets_reg > NSETS ? NSETS : sets_reg);
        if ($urandom_range(9) < 8)
            return ($urandom_range(pool - 1) * s) + (($urandom % s) & 3);
        return $urandom;
    endfunction

    initial
    begin
        sets_reg = 64;
        ways_reg = 1;
        for (int i = 0; i < NSETS*NWAYS; i++)
        begin
            tv[i] = 1'b0;
            ttag[i] = '0;
            trank[i] = '0;
        end
        rows = '{
            '{32'h0000_0000, 1'b1, 1'b0}, '{32'h0000_0000, 1'b1, 1'b1},
            '{32'hFFFF_FFFF, 1'b1, 1'b0}, '{32'hFFFF_FFFF, 1'b1, 1'b1},
            '{32'h0000_0040, 1'b1, 1'b0}, '{32'h0000_0000, 1'b1, 1'b0},
            '{32'hAAAA_AAAA, 1'b0, 1'b0}, '{32'h5555_5555, 1'b0, 1'b0}
        };
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (rows[i]) send_addr(rows[i].addr, rows[i].chk, rows[i].hit);
        drain();
        write_reg(CFG_WAYS, 32'd4);
        write_reg(CFG_SETS, 32'd1);
        for (int i = 0; i < 6; i++) send_addr(i % 5, 1'b0, 1'b0);
        drain();
        write_reg(CFG_SETS, 32'd0);
        write_reg(CFG_WAYS, 32'd0);
        send_addr(32'd7, 1'b0, 1'b0);
        send_addr(32'd7, 1'b0, 1'b0);
        drain();
        write_reg(CFG_SETS, 32'h7F);
        write_reg(CFG_WAYS, 32'hF);
        send_addr(32'h8000_0000, 1'b0, 1'b0);
        send_addr(32'h1234_5678, 1'b0, 1'b0);
        drain();
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(CFG_SETS, ph == 0 ? 32'd64 : $urandom_range(127));
            write_reg(CFG_WAYS, ph == 1 ? 32'd8 : $urandom_range(15));
            calm = (ph == 3);
            for (int i = 0; i < 75; i++)
                send_addr(pick_addr(ph == 2 ? 4 : 12), 1'b0, 1'b0);
            calm = 1'b0;
            drain();
        end
        if (errors == 0 && typed.size() == 0)
            $display("[set_assoc_cache_lru_lookup_core] OK");
        else
            $display("[set_assoc_cache_lru_lookup_core] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
